FILE: hw/rtl/otde_pkg.sv
// ----------------------------------------------------------------------------
// otde_pkg
// Shared types and constants of the text-to-DER object identifier encoder.
// ----------------------------------------------------------------------------
package otde_pkg;

	localparam int ARC_BITS   = 32;
	localparam int MAX_GROUPS = (ARC_BITS + 6) / 7;
	localparam int GROUP_BITS = 7;
	localparam int IDX_W      = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);

	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [5:0] FIRST_MUL = 6'd40;

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_BRACE,
		PH_ARCS,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_SYNTAX   = 2'd1,
		ST_OVERFLOW = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_ARC,
		BK_FIN
	} back_state_t;

	typedef struct packed {
		logic                has_arc;
		logic [ARC_BITS-1:0] arc;
		logic                has_fin;
		status_t             st;
	} cmd_t;

endpackage

FILE: hw/rtl/oid_text_to_der_encoder.sv
// ----------------------------------------------------------------------------
// oid_text_to_der_encoder
// Streams a textual object identifier in, one character per transfer, and
// streams its DER content octets out, closed by one status item.
// ----------------------------------------------------------------------------
//  channel  direction  tdata              tlast        tuser
//  s_*      in         [7:0] char_code    end_of_text  -
//  m_*      out        [7:0] octet        final_res    [0] octet_valid, [2:1] status
//
//  The parser handles characters in turn; after the last character of a
//  string it holds off input while a further step closes the string.
//  Each arc leaves as 1..5 octets, one per cycle while m_tready does not hold
//  the output, after the serialiser loads it from the queue; the status item
//  follows, and is loaded on its own when no arc closes in the same step.
//  A four-entry command queue separates parser and serialiser; the parser
//  stalls only when it is full. The output register holds a result while
//  m_tready is low. Reset clears the parse state and the queue at once.
// ----------------------------------------------------------------------------
module oid_text_to_der_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] char_code
	input  logic       s_tlast,   // end_of_text
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] octet
	output logic       m_tlast,   // final_res
	output logic [2:0] m_tuser    // [0] octet_valid, [2:1] status
);

	logic           push, full, pop, empty;
	otde_pkg::cmd_t wcmd, rcmd;

	otde_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.q_full   (full),
		.q_push   (push),
		.q_cmd    (wcmd)
	);

	otde_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (wcmd),
		.full   (full),
		.pop    (pop),
		.rdata  (rcmd),
		.empty  (empty)
	);

	otde_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (empty),
		.q_pop    (pop),
		.q_cmd    (rcmd),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

endmodule

FILE: hw/rtl/otde_front.sv
// ----------------------------------------------------------------------------
// otde_front
// Character parser: classifies each character, accumulates decimal arcs and
// queues complete arcs and the closing status for the serialiser.
// ----------------------------------------------------------------------------
module otde_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,   // [7:0] char_code
	input  logic              s_tlast,   // end_of_text
	input  logic              q_full,
	output logic              q_push,
	output otde_pkg::cmd_t    q_cmd
);

	localparam int ACC10_W = otde_pkg::ARC_BITS + 4;
	localparam int COMB_W  = otde_pkg::ARC_BITS + 7;

	otde_pkg::phase_t            ph_q, ph_d;
	otde_pkg::status_t           err_q, err_d;
	logic                        brace_q, brace_d;
	logic [1:0]                  seen_q, seen_d;
	logic [otde_pkg::ARC_BITS-1:0] acc_q, acc_d;
	logic [otde_pkg::ARC_BITS-1:0] first_q, first_d;
	logic                        innum_q, innum_d;
	logic                        eot_pend_q, eot_pend_d;
	otde_pkg::cmd_t              cmd_d;

	logic                        step_go;
	logic                        is_ws, is_dig;
	logic [3:0]                  dval;
	logic [ACC10_W-1:0]          acc10;
	logic                        dig_ovf;
	logic [COMB_W-1:0]           comb;
	logic                        comb_ovf;

	assign is_ws  = (s_tdata == otde_pkg::CH_SPACE) ||
	                ((s_tdata >= otde_pkg::CH_TAB) && (s_tdata <= otde_pkg::CH_CR));
	assign is_dig = (s_tdata >= otde_pkg::CH_ZERO) && (s_tdata <= otde_pkg::CH_NINE);
	assign dval   = 4'(s_tdata - otde_pkg::CH_ZERO);
	assign acc10  = (ACC10_W'(acc_q) << 3) + (ACC10_W'(acc_q) << 1) + ACC10_W'(dval);
	assign dig_ovf = |acc10[ACC10_W-1:otde_pkg::ARC_BITS];
	assign comb   = COMB_W'(first_q) * COMB_W'(otde_pkg::FIRST_MUL) + COMB_W'(acc_q);
	assign comb_ovf = |comb[COMB_W-1:otde_pkg::ARC_BITS];

	assign step_go = !q_full && (eot_pend_q || s_tvalid);

	always_comb begin
		logic fin_now;
		logic add_now;
		ph_d       = ph_q;
		err_d      = err_q;
		brace_d    = brace_q;
		seen_d     = seen_q;
		acc_d      = acc_q;
		first_d    = first_q;
		innum_d    = innum_q;
		eot_pend_d = eot_pend_q;
		cmd_d.has_arc = 1'b0;
		cmd_d.arc     = acc_q;
		cmd_d.has_fin = 1'b0;
		cmd_d.st      = otde_pkg::ST_OK;
		fin_now    = 1'b0;
		add_now    = 1'b0;

		if (eot_pend_q) begin
			fin_now = (ph_q == otde_pkg::PH_ARCS) && innum_q;
		end else begin
			unique case (ph_q)
				otde_pkg::PH_LEAD: begin
					if (is_ws) begin
					end else if (s_tdata == otde_pkg::CH_LBRACE) begin
						brace_d = 1'b1;
						ph_d    = otde_pkg::PH_BRACE;
					end else if (is_dig) begin
						ph_d    = otde_pkg::PH_ARCS;
						add_now = 1'b1;
					end else begin
						ph_d  = otde_pkg::PH_DONE;
						err_d = otde_pkg::ST_SYNTAX;
					end
				end
				otde_pkg::PH_BRACE: begin
					if (is_ws) begin
					end else if (is_dig) begin
						ph_d    = otde_pkg::PH_ARCS;
						add_now = 1'b1;
					end else begin
						ph_d  = otde_pkg::PH_DONE;
						err_d = otde_pkg::ST_SYNTAX;
					end
				end
				otde_pkg::PH_ARCS: begin
					if (is_dig) add_now = 1'b1;
					else fin_now = innum_q;
				end
				default: begin
				end
			endcase
		end

		if (add_now) begin
			if (dig_ovf) begin
				ph_d  = otde_pkg::PH_DONE;
				err_d = otde_pkg::ST_OVERFLOW;
			end else begin
				acc_d   = acc10[otde_pkg::ARC_BITS-1:0];
				innum_d = 1'b1;
			end
		end

		if (fin_now) begin
			innum_d = 1'b0;
			acc_d   = '0;
			if (seen_q == 2'd0) begin
				first_d = acc_q;
				seen_d  = 2'd1;
			end else if (seen_q == 2'd1) begin
				if (comb_ovf) begin
					ph_d  = otde_pkg::PH_DONE;
					err_d = otde_pkg::ST_OVERFLOW;
				end else begin
					seen_d        = 2'd2;
					cmd_d.has_arc = 1'b1;
					cmd_d.arc     = comb[otde_pkg::ARC_BITS-1:0];
				end
			end else begin
				cmd_d.has_arc = 1'b1;
				cmd_d.arc     = acc_q;
			end
		end

		if (eot_pend_q) begin
			if (ph_d == otde_pkg::PH_ARCS) begin
				err_d = ((seen_d != 2'd2) || brace_q) ? otde_pkg::ST_SYNTAX : otde_pkg::ST_OK;
			end else if (ph_d != otde_pkg::PH_DONE) begin
				err_d = otde_pkg::ST_SYNTAX;
			end
			cmd_d.has_fin = 1'b1;
			cmd_d.st      = err_d;
			ph_d       = otde_pkg::PH_LEAD;
			err_d      = otde_pkg::ST_OK;
			brace_d    = 1'b0;
			seen_d     = 2'd0;
			acc_d      = '0;
			first_d    = '0;
			innum_d    = 1'b0;
			eot_pend_d = 1'b0;
		end else begin
			if ((ph_q == otde_pkg::PH_ARCS) && !is_dig && !is_ws &&
			    (ph_d == otde_pkg::PH_ARCS)) begin
				ph_d = otde_pkg::PH_DONE;
				if (seen_d != 2'd2) err_d = otde_pkg::ST_SYNTAX;
				else if (brace_q && (s_tdata != otde_pkg::CH_RBRACE)) err_d = otde_pkg::ST_SYNTAX;
				else err_d = otde_pkg::ST_OK;
			end
			eot_pend_d = s_tlast;
		end
	end

	always_comb begin
		s_tready = !q_full && !eot_pend_q;
		q_push   = step_go && (cmd_d.has_arc || cmd_d.has_fin);
		q_cmd    = cmd_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q       <= otde_pkg::PH_LEAD;
			err_q      <= otde_pkg::ST_OK;
			brace_q    <= 1'b0;
			seen_q     <= 2'd0;
			acc_q      <= '0;
			first_q    <= '0;
			innum_q    <= 1'b0;
			eot_pend_q <= 1'b0;
		end else if (step_go) begin
			ph_q       <= ph_d;
			err_q      <= err_d;
			brace_q    <= brace_d;
			seen_q     <= seen_d;
			acc_q      <= acc_d;
			first_q    <= first_d;
			innum_q    <= innum_d;
			eot_pend_q <= eot_pend_d;
		end
	end

	a_eot_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		eot_pend_q |-> !s_tready)
		else $error("input taken while end of text pending");

	a_fin_only_at_eot: assert property (@(posedge clk) disable iff (!arst_n)
		(q_push && q_cmd.has_fin) |-> eot_pend_q)
		else $error("status queued outside end of text step");

endmodule

FILE: hw/rtl/otde_fifo.sv
// ----------------------------------------------------------------------------
// otde_fifo
// Short command queue between the parser and the octet serialiser.
// ----------------------------------------------------------------------------
module otde_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  otde_pkg::cmd_t wdata,
	output logic           full,
	input  logic           pop,
	output otde_pkg::cmd_t rdata,
	output logic           empty
);

	otde_pkg::cmd_t                mem_q [otde_pkg::QDEPTH];
	logic [otde_pkg::QPTR_W-1:0]   wptr_q, rptr_q;
	logic [otde_pkg::QPTR_W:0]     cnt_q;

	assign full  = (cnt_q == (otde_pkg::QPTR_W+1)'(otde_pkg::QDEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) wptr_q <= wptr_q + 1'b1;
			if (pop) rptr_q <= rptr_q + 1'b1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("queue overrun");

	a_no_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue underrun");

endmodule

FILE: hw/rtl/otde_back.sv
// ----------------------------------------------------------------------------
// otde_back
// Octet serialiser: splits each queued arc into base-128 groups, most
// significant first, and issues the closing status item.
// ----------------------------------------------------------------------------
module otde_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_empty,
	output logic           q_pop,
	input  otde_pkg::cmd_t q_cmd,
	output logic           m_tvalid,
	input  logic           m_tready,
	output logic [7:0]     m_tdata,   // [7:0] octet
	output logic           m_tlast,   // final_res
	output logic [2:0]     m_tuser    // [0] octet_valid, [2:1] status
);

	localparam int EXT_W = otde_pkg::MAX_GROUPS * otde_pkg::GROUP_BITS;

	otde_pkg::back_state_t          state_q, state_d;
	logic [otde_pkg::ARC_BITS-1:0]  arc_q;
	logic                           fin_q;
	otde_pkg::status_t              st_q;
	logic [otde_pkg::IDX_W-1:0]     idx_q;
	logic                           m_tvalid_q;
	logic [7:0]                     m_tdata_q;
	logic                           m_tlast_q;
	logic [2:0]                     m_tuser_q;

	logic                           out_free;
	logic                           emit_arc, emit_fin;
	logic [EXT_W-1:0]               head_ext, cur_ext;
	logic [otde_pkg::IDX_W-1:0]     top_grp;
	logic [6:0]                     grp;

	assign out_free = !m_tvalid_q || m_tready;
	assign head_ext = EXT_W'(q_cmd.arc);
	assign cur_ext  = EXT_W'(arc_q);
	assign grp      = cur_ext[int'(idx_q)*otde_pkg::GROUP_BITS +: otde_pkg::GROUP_BITS];

	always_comb begin
		top_grp = '0;
		for (int g = 1; g < otde_pkg::MAX_GROUPS; g++) begin
			if (head_ext[g*otde_pkg::GROUP_BITS +: otde_pkg::GROUP_BITS] != '0)
				top_grp = otde_pkg::IDX_W'(g);
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			otde_pkg::BK_IDLE: begin
				if (!q_empty) state_d = q_cmd.has_arc ? otde_pkg::BK_ARC : otde_pkg::BK_FIN;
			end
			otde_pkg::BK_ARC: begin
				if (out_free && (idx_q == '0))
					state_d = fin_q ? otde_pkg::BK_FIN : otde_pkg::BK_IDLE;
			end
			otde_pkg::BK_FIN: begin
				if (out_free) state_d = otde_pkg::BK_IDLE;
			end
			default: state_d = otde_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		q_pop    = (state_q == otde_pkg::BK_IDLE) && !q_empty;
		emit_arc = (state_q == otde_pkg::BK_ARC) && out_free;
		emit_fin = (state_q == otde_pkg::BK_FIN) && out_free;
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			arc_q <= q_cmd.arc;
			fin_q <= q_cmd.has_fin;
			st_q  <= q_cmd.st;
			idx_q <= top_grp;
		end else if (emit_arc && (idx_q != '0)) begin
			idx_q <= idx_q - 1'b1;
		end
		if (emit_arc) begin
			m_tdata_q <= {(idx_q != '0), grp};
			m_tlast_q <= 1'b0;
			m_tuser_q <= {otde_pkg::ST_OK, 1'b1};
		end else if (emit_fin) begin
			m_tdata_q <= 8'h00;
			m_tlast_q <= 1'b1;
			m_tuser_q <= {st_q, 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= otde_pkg::BK_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit_arc || emit_fin) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;
	assign m_tuser  = m_tuser_q;

	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == otde_pkg::BK_ARC) |->
		(int'(idx_q) < otde_pkg::MAX_GROUPS))
		else $error("group index out of range");

endmodule
